// ----- rtl/core/tpss_pkg.sv -----
// Shared constants and types for the timed pattern step sequencer.
package tpss_pkg;

  localparam int unsigned ShowSlots = 4;
  localparam int unsigned Tracks    = 8;
  localparam int unsigned MaxSteps  = 64;
  localparam int unsigned SlotW     = $clog2(ShowSlots);
  localparam int unsigned TrackW    = $clog2(Tracks);
  localparam int unsigned PosW      = $clog2(MaxSteps);
  localparam int unsigned CountW    = PosW + 1;
  localparam int unsigned PatAddrW  = SlotW + TrackW + PosW;
  localparam int unsigned KindDepth = ShowSlots * Tracks;
  localparam logic [7:0]  FullLevel = 8'd100;

  // Input actions
  localparam logic [2:0] ActTick   = 3'd0;
  localparam logic [2:0] ActPlay   = 3'd1;
  localparam logic [2:0] ActStop   = 3'd2;
  localparam logic [2:0] ActPatt   = 3'd3;
  localparam logic [2:0] ActHeader = 3'd4;

  // Track kinds: valve, any other code is a light
  localparam logic [1:0] TrackValve = 2'd0;

  // Result kinds
  localparam logic [1:0] KindDrive    = 2'd0;
  localparam logic [1:0] KindNotFound = 2'd1;
  localparam logic [1:0] KindFinished = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  slot;
    logic [2:0]  track;
    logic [5:0]  step_index;
    logic [7:0]  step_value;
    logic [1:0]  track_kind;
    logic [7:0]  show_id;
    logic [15:0] step_period;
    logic [6:0]  step_count;
    logic        loop_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] out_track;
    logic [7:0] level;
    logic       last;
  } out_item_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic               latch;      // capture input item, do writes
    logic               search_clr; // reset slot search
    logic               search_step;// examine next slot
    logic               start_show; // running=1, slot=found, pos=0, countdown=period
    logic               cnt_dec;    // countdown--
    logic               advance;    // pos=next, countdown=period
    logic               wrap;       // pos=0 variant of advance
    logic               halt_regs;  // running=0 and clear
    logic               trk_clr;    // track counter to 0
    logic               trk_inc;    // track counter +1
    logic               rd_issue;   // issue memory read for current track
    logic               off_mode;   // target is zero (all off)
    logic               drive_chk;  // compare and maybe emit drive update
    logic               emit_misc;  // emit non-drive result
    logic [1:0]         misc_kind;
    logic               misc_last;
    logic               out_take;   // pending result handed to output
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [2:0] action;
    logic       running;
    logic       cnt_gt1;
    logic       at_end;
    logic       loop_on;
    logic       search_done;
    logic       found;
    logic       trk_last;
    logic       out_busy;
    logic       pend;
  } dp_stat_t;

endpackage

// ----- rtl/core/tpss_if.sv -----
// Valid/ready channel interfaces for input items and results.
interface tpss_in_if;
  logic                 valid;
  logic                 ready;
  tpss_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpss_out_if;
  logic                 valid;
  logic                 ready;
  tpss_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/timed_pattern_step_sequencer.sv -----
// An item without results passes through idle, decode, flush and done; a step walk
// reads each track's pattern byte (registered read), then compares it; play over a
// running show walks twice, first to drive zero, then for the new show.
// A result is staged until the next one or the item end decides its last bit; the walk
// stalls while the output register is held by the receiver.
// Throughput: one item at a time. Reset: async active low; pattern memory not reset.
module timed_pattern_step_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpss_in_if.sink     in_ch,
  tpss_out_if.source  out_ch
);

  tpss_pkg::dp_cmd_t  cmd;
  tpss_pkg::dp_stat_t stat;

  tpss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tpss_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_ch.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (out_ch.data)
  );

endmodule

// ----- rtl/core/tpss_datapath.sv -----
// Datapath: stores, play state, drive shadow, result staging and output register.
module tpss_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tpss_pkg::in_item_t   item_i,
  input  tpss_pkg::dp_cmd_t    cmd_i,
  output tpss_pkg::dp_stat_t   stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tpss_pkg::out_item_t  out_data_o
);

  // Captured item
  tpss_pkg::in_item_t item_q;

  // Pattern memory, undefined until written
  logic [7:0] pat_mem [2**tpss_pkg::PatAddrW];
  logic [7:0] pat_rd_q;
  logic [1:0] kind_rd_q;

  // Kind store and slot headers
  logic [1:0]  kind_q   [tpss_pkg::KindDepth];
  logic [7:0]  id_q     [tpss_pkg::ShowSlots];
  logic [15:0] period_q [tpss_pkg::ShowSlots];
  logic [tpss_pkg::CountW-1:0] steps_q [tpss_pkg::ShowSlots];
  logic        loop_q   [tpss_pkg::ShowSlots];

  logic                        running_q;
  logic [tpss_pkg::SlotW-1:0]  act_q;
  logic [tpss_pkg::PosW-1:0]   pos_q;
  logic [15:0]                 cnt_q;
  logic [7:0]                  shadow_q [tpss_pkg::Tracks];

  logic [tpss_pkg::SlotW:0]    srch_q;
  logic                        found_q;
  logic [tpss_pkg::TrackW-1:0] trk_q;
  logic [tpss_pkg::TrackW-1:0] rd_trk_q;

  // Pending result (holds last bit decided later) and output register
  logic                        pend_q;
  tpss_pkg::out_item_t         pend_data_q;
  logic                        ov_q;
  tpss_pkg::out_item_t         od_q;

  logic [tpss_pkg::CountW-1:0] next_pos;
  logic [7:0]                  target;
  logic                        do_emit;
  logic                        take;
  logic [tpss_pkg::SlotW-1:0]  srch_idx;
  logic                        srch_hit;
  logic [tpss_pkg::CountW-1:0] cnt_clamp;

  assign srch_idx = srch_q[tpss_pkg::SlotW-1:0];
  assign srch_hit = (item_q.show_id != 8'd0) && (id_q[srch_idx] == item_q.show_id);
  assign next_pos = {1'b0, pos_q} + 1'b1;

  // Target level for the track whose bytes were most recently read
  always_comb begin
    if (cmd_i.off_mode) begin
      target = 8'd0;
    end else if (kind_rd_q == tpss_pkg::TrackValve) begin
      target = (pat_rd_q != 8'd0) ? 8'd1 : 8'd0;
    end else if (pat_rd_q == 8'd1) begin
      target = tpss_pkg::FullLevel;
    end else begin
      target = pat_rd_q;
    end
  end

  assign do_emit = cmd_i.drive_chk && (shadow_q[rd_trk_q] != target);

  // A new drive update pushes the staged one (now known not last) to the output
  assign take = cmd_i.out_take || (do_emit && pend_q);

  // Header count clamp
  always_comb begin
    if (item_q.step_count == 7'd0) begin
      cnt_clamp = tpss_pkg::CountW'(1);
    end else if ({1'b0, item_q.step_count} > 8'(tpss_pkg::MaxSteps)) begin
      cnt_clamp = tpss_pkg::CountW'(tpss_pkg::MaxSteps);
    end else begin
      cnt_clamp = tpss_pkg::CountW'(item_q.step_count);
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
  end

  // Pattern memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch && item_i.action == tpss_pkg::ActPatt) begin
      pat_mem[{item_i.slot, item_i.track, item_i.step_index}] <= item_i.step_value;
    end
    if (cmd_i.rd_issue) begin
      pat_rd_q  <= pat_mem[{act_q, trk_q, pos_q}];
      kind_rd_q <= kind_q[{act_q, trk_q}];
      rd_trk_q  <= trk_q;
    end
  end

  // Slot headers and kinds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tpss_pkg::KindDepth; i++) kind_q[i] <= 2'd0;
      for (int s = 0; s < tpss_pkg::ShowSlots; s++) begin
        id_q[s]     <= 8'd0;
        period_q[s] <= 16'd1;
        steps_q[s]  <= tpss_pkg::CountW'(1);
        loop_q[s]   <= 1'b0;
      end
    end else if (cmd_i.latch) begin
      if (item_i.action == tpss_pkg::ActPatt) begin
        kind_q[{item_i.slot, item_i.track}] <= item_i.track_kind;
      end
      if (item_i.action == tpss_pkg::ActHeader) begin
        id_q[item_i.slot] <= item_i.show_id;
      end
    end else if (item_q.action == tpss_pkg::ActHeader && cmd_i.search_clr) begin
      period_q[item_q.slot] <= (item_q.step_period == 16'd0) ? 16'd1 : item_q.step_period;
      steps_q[item_q.slot]  <= cnt_clamp;
      loop_q[item_q.slot]   <= item_q.loop_flag;
    end
  end

  // Play state, search, track walk, shadow and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      act_q     <= '0;
      pos_q     <= '0;
      cnt_q     <= 16'd0;
      srch_q    <= '0;
      found_q   <= 1'b0;
      trk_q     <= '0;
      pend_q    <= 1'b0;
      pend_data_q <= '0;
      ov_q      <= 1'b0;
      od_q      <= '0;
      for (int t = 0; t < tpss_pkg::Tracks; t++) shadow_q[t] <= 8'd0;
    end else begin
      if (cmd_i.search_clr) begin
        srch_q  <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.search_step) begin
        if (srch_hit) begin
          found_q <= 1'b1;
        end else begin
          srch_q <= srch_q + 1'b1;
        end
      end
      if (cmd_i.halt_regs) begin
        running_q <= 1'b0;
        act_q     <= '0;
        pos_q     <= '0;
        cnt_q     <= 16'd0;
      end else if (cmd_i.start_show) begin
        running_q <= 1'b1;
        act_q     <= srch_idx;
        pos_q     <= '0;
        cnt_q     <= period_q[srch_idx];
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - 16'd1;
      end else if (cmd_i.advance) begin
        pos_q <= cmd_i.wrap ? '0 : next_pos[tpss_pkg::PosW-1:0];
        cnt_q <= period_q[act_q];
      end
      if (cmd_i.trk_clr) begin
        trk_q <= '0;
      end else if (cmd_i.trk_inc) begin
        trk_q <= trk_q + 1'b1;
      end
      // output register
      if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (take) begin
        ov_q <= 1'b1;
        od_q <= pend_data_q;
        pend_q <= 1'b0;
      end
      if (do_emit) begin
        shadow_q[rd_trk_q] <= target;
        pend_q <= 1'b1;
        pend_data_q <= '{kind: tpss_pkg::KindDrive, out_track: rd_trk_q,
                         level: target, last: 1'b0};
      end else if (cmd_i.emit_misc) begin
        pend_q <= 1'b1;
        pend_data_q <= '{kind: cmd_i.misc_kind, out_track: 3'd0,
                         level: 8'd0, last: cmd_i.misc_last};
      end else if (cmd_i.misc_last && pend_q && !take) begin
        pend_data_q.last <= 1'b1;
      end
    end
  end

  assign stat_o = '{
    action:      item_q.action,
    running:     running_q,
    cnt_gt1:     cnt_q > 16'd1,
    at_end:      next_pos >= steps_q[act_q],
    loop_on:     loop_q[act_q],
    search_done: found_q || (srch_q == (tpss_pkg::SlotW+1)'(tpss_pkg::ShowSlots)),
    found:       found_q,
    trk_last:    trk_q == tpss_pkg::TrackW'(tpss_pkg::Tracks - 1),
    out_busy:    ov_q && !out_ready_i,
    pend:        pend_q
  };

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

// ----- rtl/core/tpss_ctrl.sv -----
// Controller state machine sequencing each item through the datapath.
module tpss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tpss_pkg::dp_stat_t stat_i,
  output tpss_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    StIdle   = 8'b00000001,
    StDecode = 8'b00000010,
    StSearch = 8'b00000100,
    StWalk   = 8'b00001000,
    StChk    = 8'b00010000,
    StMisc   = 8'b00100000,
    StFlush  = 8'b01000000,
    StDone   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  // off_q: walk drives zero; then_q: after off walk, start new show
  logic off_q, off_d, then_q, then_d, fin_q, fin_d;

  // Pending result moves to the output register when it is free and a
  // following result exists or the item is over (last is known then).
  logic can_take;
  assign can_take = stat_i.pend && !stat_i.out_busy;

  always_comb begin
    state_d = state_q;
    off_d   = off_q;
    then_d  = then_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.off_mode = off_q;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        cmd_o.search_clr = 1'b1;
        cmd_o.trk_clr    = 1'b1;
        off_d = 1'b0; then_d = 1'b0; fin_d = 1'b0;
        state_d = StFlush;
        case (stat_i.action)
          tpss_pkg::ActTick: begin
            if (stat_i.running) begin
              if (stat_i.cnt_gt1) begin
                cmd_o.cnt_dec = 1'b1;
              end else if (stat_i.at_end && !stat_i.loop_on) begin
                off_d = 1'b1; fin_d = 1'b1; state_d = StWalk;
              end else begin
                cmd_o.advance = 1'b1;
                cmd_o.wrap = stat_i.at_end;
                state_d = StWalk;
              end
            end
          end
          tpss_pkg::ActPlay: state_d = StSearch;
          tpss_pkg::ActStop: begin
            if (stat_i.running) begin
              off_d = 1'b1; state_d = StWalk;
            end
          end
          default: ;
        endcase
      end
      StSearch: begin
        if (stat_i.search_done) begin
          if (!stat_i.found) begin
            state_d = StMisc;
          end else if (stat_i.running) begin
            off_d = 1'b1; then_d = 1'b1; state_d = StWalk;
          end else begin
            cmd_o.start_show = 1'b1; state_d = StWalk;
          end
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      StWalk: begin
        // read pattern byte and kind of the current track
        cmd_o.rd_issue = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        // a staged result can only be displaced when the output register frees
        if (stat_i.pend && stat_i.out_busy) begin
          state_d = StChk;
        end else begin
          cmd_o.drive_chk = 1'b1;
          if (stat_i.trk_last) begin
            cmd_o.trk_clr = 1'b1;
            if (then_q) begin
              cmd_o.halt_regs = 1'b1;
              then_d = 1'b0; off_d = 1'b0;
              state_d = StSearch;
            end else if (off_q) begin
              cmd_o.halt_regs = 1'b1;
              state_d = fin_q ? StMisc : StFlush;
            end else begin
              state_d = StFlush;
            end
          end else begin
            cmd_o.trk_inc = 1'b1;
            state_d = StWalk;
          end
        end
      end
      StMisc: begin
        if (stat_i.pend) begin
          cmd_o.out_take = can_take;
        end else begin
          cmd_o.emit_misc = 1'b1;
          cmd_o.misc_kind = fin_q ? tpss_pkg::KindFinished : tpss_pkg::KindNotFound;
          cmd_o.misc_last = 1'b1;
          state_d = StDone;
        end
      end
      StFlush: begin
        // mark staged result as last
        cmd_o.misc_last = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        if (!stat_i.pend) begin
          state_d = StIdle;
        end else begin
          cmd_o.out_take = can_take;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      off_q   <= 1'b0;
      then_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      off_q   <= off_d;
      then_q  <= then_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ----- tb/tb_timed_pattern_step_sequencer.sv -----
// Self-checking testbench for the timed pattern step sequencer.
module tb_timed_pattern_step_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemGoal   = 480;
  localparam int unsigned NSlots     = tpss_pkg::ShowSlots;
  localparam int unsigned NTracks    = tpss_pkg::Tracks;
  localparam int unsigned NSteps     = tpss_pkg::MaxSteps;

  logic clk_i;
  logic rst_ni;

  tpss_in_if  in_ch ();
  tpss_out_if out_ch ();

  timed_pattern_step_sequencer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Predicted sequencer state
  logic [7:0]  pat_mem [NSlots][NTracks][NSteps];
  logic [1:0]  trk_kind [NSlots][NTracks];
  logic [7:0]  show_id [NSlots];
  logic [15:0] show_period [NSlots];
  logic [6:0]  show_steps [NSlots];
  logic        show_loop [NSlots];
  logic        playing;
  logic [1:0]  cur_slot;
  logic [5:0]  cur_pos;
  logic [15:0] ms_left;
  logic [7:0]  drive_level [NTracks];

  // Pattern bytes written so far; play must never read an unwritten one
  bit          pat_written [NSlots][NTracks][NSteps];

  tpss_pkg::in_item_t  pending_items [$];
  tpss_pkg::out_item_t due_results [$];
  tpss_pkg::out_item_t step_out [$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          long_hold;
  bit          took;
  int unsigned cycles;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned items_queued;
  int unsigned results_seen;
  int unsigned shows_ended;
  int unsigned misses;

  // Append one expected result of the current item
  function automatic void add_result(tpss_pkg::out_item_t r);
    step_out = {step_out, r};
  endfunction

  // Update one drive and record a change against the shadow
  function automatic void set_drive(int t, logic [7:0] lvl);
    if (drive_level[t] != lvl) begin
      drive_level[t] = lvl;
      add_result('{kind: tpss_pkg::KindDrive, out_track: t[2:0], level: lvl, last: 1'b0});
    end
  endfunction

  function automatic void apply_pos();
    logic [7:0] v;
    logic [7:0] tgt;
    for (int t = 0; t < NTracks; t++) begin
      v = pat_mem[cur_slot][t][cur_pos];
      if (trk_kind[cur_slot][t] == tpss_pkg::TrackValve) tgt = (v != 0) ? 8'd1 : 8'd0;
      else if (v == 8'd1) tgt = tpss_pkg::FullLevel;
      else tgt = v;
      set_drive(t, tgt);
    end
  endfunction

  function automatic void halt_show();
    for (int t = 0; t < NTracks; t++) set_drive(t, 8'd0);
    playing  = 1'b0;
    cur_slot = '0;
    cur_pos  = '0;
    ms_left  = '0;
  endfunction

  // Expected results of one accepted item
  function automatic void sequencer_step(tpss_pkg::in_item_t it);
    logic [6:0] nxt;
    logic [6:0] cnt;
    int         s;
    step_out.delete();
    case (it.action)
      tpss_pkg::ActTick: begin
        if (playing) begin
          if (ms_left > 1) begin
            ms_left--;
          end else begin
            nxt = {1'b0, cur_pos} + 7'd1;
            if (nxt >= show_steps[cur_slot] && !show_loop[cur_slot]) begin
              halt_show();
              add_result('{kind: tpss_pkg::KindFinished, out_track: 3'd0, level: 8'd0,
                           last: 1'b0});
              shows_ended++;
            end else begin
              if (nxt >= show_steps[cur_slot]) nxt = '0;
              cur_pos = nxt[5:0];
              ms_left = show_period[cur_slot];
              apply_pos();
            end
          end
        end
      end
      tpss_pkg::ActPlay: begin
        s = NSlots;
        for (int i = NSlots - 1; i >= 0; i--)
          if (it.show_id != 0 && show_id[i] == it.show_id) s = i;
        if (s == NSlots) begin
          add_result('{kind: tpss_pkg::KindNotFound, out_track: 3'd0, level: 8'd0,
                       last: 1'b0});
          misses++;
        end else begin
          if (playing) halt_show();
          playing  = 1'b1;
          cur_slot = s[1:0];
          cur_pos  = '0;
          ms_left  = show_period[s];
          apply_pos();
        end
      end
      tpss_pkg::ActStop: begin
        if (playing) halt_show();
      end
      tpss_pkg::ActPatt: begin
        pat_mem[it.slot][it.track][it.step_index] = it.step_value;
        trk_kind[it.slot][it.track] = it.track_kind;
      end
      tpss_pkg::ActHeader: begin
        cnt = it.step_count;
        if (cnt < 1) cnt = 1;
        if (cnt > NSteps) cnt = 7'(NSteps);
        show_id[it.slot]     = it.show_id;
        show_period[it.slot] = (it.step_period != 0) ? it.step_period : 16'd1;
        show_steps[it.slot]  = cnt;
        show_loop[it.slot]   = it.loop_flag;
      end
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    due_results = {due_results, step_out};
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Number of leading steps written on every track of a slot
  function automatic int covered_steps(int s);
    for (int p = 0; p < NSteps; p++)
      for (int t = 0; t < NTracks; t++)
        if (!pat_written[s][t][p]) return p;
    return NSteps;
  endfunction

  function automatic int clamp_count(logic [6:0] c);
    if (c < 1) return 1;
    if (c > NSteps) return NSteps;
    return c;
  endfunction

  function automatic tpss_pkg::in_item_t noise_item();
    tpss_pkg::in_item_t it;
    it = tpss_pkg::in_item_t'({$urandom, $urandom});
    return it;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_item(tpss_pkg::in_item_t it);
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  task automatic queue_patt(int s, int t, int p, logic [7:0] v, logic [1:0] k);
    tpss_pkg::in_item_t it;
    it = noise_item();
    it.action     = tpss_pkg::ActPatt;
    it.slot       = s[1:0];
    it.track      = t[2:0];
    it.step_index = p[5:0];
    it.step_value = v;
    it.track_kind = k;
    pat_written[s][t][p] = 1'b1;
    queue_item(it);
  endtask

  task automatic queue_simple(logic [2:0] act, logic [7:0] id);
    tpss_pkg::in_item_t it;
    it = noise_item();
    it.action  = act;
    it.show_id = id;
    queue_item(it);
  endtask

  // Slots that may be played, or be playing, before the current batch drains
  bit maybe_live [NSlots];

  // Header write kept legal: a slot that can be played covers its step count
  task automatic queue_header(int s, logic [7:0] id, logic [15:0] per, logic [6:0] cnt,
                              logic lp);
    tpss_pkg::in_item_t it;
    int       cov;
    cov = covered_steps(s);
    if ((id != 0 || maybe_live[s]) && cov < clamp_count(cnt)) begin
      if (cov >= 1) cnt = 7'($urandom_range(1, cov));
      else id = 8'd0;
    end
    if (id != 0) maybe_live[s] = 1'b1;
    it = noise_item();
    it.action      = tpss_pkg::ActHeader;
    it.slot        = s[1:0];
    it.show_id     = id;
    it.step_period = per;
    it.step_count  = cnt;
    it.loop_flag   = lp;
    queue_item(it);
  endtask

  task automatic begin_batch();
    for (int s = 0; s < NSlots; s++)
      maybe_live[s] = (show_id[s] != 0) || (playing && cur_slot == s);
  endtask

  // Wait until every queued item is taken and every result has arrived
  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || due_results.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic directed_batch();
    logic [7:0] vals [4];
    vals = '{8'd0, 8'd1, 8'd255, 8'd2};
    begin_batch();
    // two steps on slot 0, every kind including the spare code
    for (int p = 0; p < 2; p++)
      for (int t = 0; t < NTracks; t++)
        queue_patt(0, t, p, vals[(t + p) % 4], t[1:0]);
    queue_header(0, 8'd255, 16'd0, 7'd2, 1'b1);       // period zero stored as one
    queue_header(1, 8'd0, 16'd7, 7'd0, 1'b0);         // zero count stored as one
    queue_header(2, 8'd0, 16'hFFFF, 7'd127, 1'b1);    // count clamped to maximum
    queue_simple(tpss_pkg::ActPlay, 8'd0);            // id zero never matches
    queue_simple(tpss_pkg::ActPlay, 8'd7);
    queue_simple(tpss_pkg::ActPlay, 8'd255);
    repeat (3) queue_simple(tpss_pkg::ActTick, 8'd0);
    queue_simple(tpss_pkg::ActPlay, 8'd255);          // restart while playing
    queue_simple(3'd5, 8'd255);
    queue_simple(3'd6, 8'd255);
    queue_simple(3'd7, 8'd255);
    queue_simple(tpss_pkg::ActPlay, 8'd9);            // miss keeps show running
    queue_simple(tpss_pkg::ActTick, 8'd0);
    queue_simple(tpss_pkg::ActStop, 8'd0);
    queue_simple(tpss_pkg::ActStop, 8'd0);
    queue_simple(tpss_pkg::ActTick, 8'd0);
    queue_header(0, 8'd255, 16'd1, 7'd2, 1'b0);       // no loop: show ends
    queue_simple(tpss_pkg::ActPlay, 8'd255);
    repeat (3) queue_simple(tpss_pkg::ActTick, 8'd0);
  endtask

  task automatic random_batch();
    int         s;
    int         n;
    int         k;
    int         r;
    logic [7:0] id;
    logic [15:0] per;
    logic [6:0] cnt;
    begin_batch();
    s = $urandom_range(NSlots - 1);
    n = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    for (int p = 0; p < n; p++)
      for (int t = 0; t < NTracks; t++)
        queue_patt(s, t, p, pick_byte(), 2'($urandom_range(3)));
    id  = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 6));
    per = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    case ($urandom_range(5))
      0: cnt = 7'd0;
      1: cnt = 7'($urandom_range(0, 127));
      default: cnt = 7'(n);
    endcase
    queue_header(s, id, per, cnt, 1'($urandom_range(1)));
    queue_simple(tpss_pkg::ActPlay, ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : id);
    k = $urandom_range(6, 24);
    repeat (k) begin
      r = $urandom_range(99);
      if (r < 72) queue_simple(tpss_pkg::ActTick, 8'($urandom));
      else if (r < 77) queue_simple(tpss_pkg::ActStop, 8'($urandom));
      else if (r < 84) queue_simple(tpss_pkg::ActPlay, 8'($urandom_range(0, 8)));
      else if (r < 88) queue_simple(3'($urandom_range(5, 7)), 8'($urandom));
      else if (r < 94)
        queue_header($urandom_range(NSlots - 1), 8'($urandom_range(0, 8)),
                     16'($urandom_range(0, 2)), 7'($urandom), 1'($urandom_range(1)));
      else
        queue_patt($urandom_range(NSlots - 1), $urandom_range(NTracks - 1),
                   $urandom_range(NSteps - 1), pick_byte(), 2'($urandom_range(3)));
    end
  endtask

  // Main sequence: reset, directed batch, then random batches over idle and stall modes
  initial begin
    int batch;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    long_hold    = 1'b0;
    took         = 1'b0;
    cycles       = 0;
    errors       = 0;
    items_sent   = 0;
    items_queued = 0;
    results_seen = 0;
    shows_ended  = 0;
    misses       = 0;
    playing      = 1'b0;
    cur_slot     = '0;
    cur_pos      = '0;
    ms_left      = '0;
    for (int s = 0; s < NSlots; s++) begin
      show_id[s]     = '0;
      show_period[s] = 16'd1;
      show_steps[s]  = 7'd1;
      show_loop[s]   = 1'b0;
      for (int t = 0; t < NTracks; t++) begin
        trk_kind[s][t] = '0;
        for (int p = 0; p < NSteps; p++) pat_written[s][t][p] = 1'b0;
      end
    end
    for (int t = 0; t < NTracks; t++) drive_level[t] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_batch();
    drain();
    batch = 0;
    while (items_queued < ItemGoal) begin
      case (batch % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      // one long receiver hold-off while the sender keeps offering
      if (batch == 2) long_hold = 1'b1;
      random_batch();
      drain();
      batch++;
    end
    repeat (60) @(posedge clk_i);
    $display("Covered %0d items, %0d results checked, %0d shows ended, %0d misses.",
             items_sent, results_seen, shows_ended, misses);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb_timed_pattern_step_sequencer passed");
    end else begin
      $display("Errors: %0d, results still due: %0d", errors, due_results.size());
      $display("tb_timed_pattern_step_sequencer failed");
    end
    $finish;
  end

  // Long hold-off, counted in its own process
  initial begin
    wait (long_hold);
    repeat (400) @(negedge clk_i);
    long_hold = 1'b0;
  end

  // Driver: offer the next item at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || took) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_ch.data  <= pending_items.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end
    took = 1'b0;
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin
    tpss_pkg::out_item_t want;
    tpss_pkg::out_item_t got;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("tb_timed_pattern_step_sequencer failed");
      $finish;
    end else if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sequencer_step(in_ch.data);
        items_sent++;
        took = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected result kind=%0d track=%0d level=%0d last=%0d",
                     got.kind, got.out_track, got.level, got.last);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.out_track !== want.out_track ||
              got.level !== want.level || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"Mismatch: want kind=%0d track=%0d level=%0d last=%0d,",
                        " got %0d %0d %0d %0d"},
                       want.kind, want.out_track, want.level, want.last,
                       got.kind, got.out_track, got.level, got.last);
          end
        end
      end
    end
  end

endmodule

// ----- timed_pattern_step_sequencer.f -----
rtl/core/tpss_pkg.sv
rtl/core/tpss_if.sv
rtl/core/tpss_datapath.sv
rtl/core/tpss_ctrl.sv
rtl/core/timed_pattern_step_sequencer.sv
tb/tb_timed_pattern_step_sequencer.sv
